### src/mlfq_pkg.sv
// shared types and constants for the multilevel feedback queue scheduler
package mlfq_pkg;

  localparam int unsigned QuantWidth = 16;
  localparam int unsigned PidWidth   = 6;
  localparam int unsigned ReqWidth   = 3;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [ReqWidth-1:0] {
    REQ_ADD     = 3'd0,
    REQ_PICK    = 3'd1,
    REQ_QUERY   = 3'd2,
    REQ_REQUEUE = 3'd3,
    REQ_TICK    = 3'd4
  } req_e;

  localparam logic [CfgIdxW-1:0] CFG_Q0    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_Q1    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_Q2    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_Q3    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BOOST = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, look up level
    logic exec;      // perform the request
    logic boost_pop; // read head of lowest non-zero level
    logic boost_mv;  // move read entry to level 0
    logic out_load;  // capture result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic boost_start; // tick reached interval
    logic upper_busy;  // some level above 0 still non-empty
  } sts_t;

endpackage

### src/mlfq_ctrl.sv
// controller state machine for the scheduler
module mlfq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic          out_free_i,
  input  mlfq_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output mlfq_pkg::cmd_t cmd_o
);
  import mlfq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_BRD  = 6'b000100,
    S_BMV  = 6'b001000,
    S_OUT  = 6'b010000,
    S_CHK  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_CHK;
      end
      S_CHK: begin
        if (sts_i.boost_start && sts_i.upper_busy) state_d = S_BRD;
        else state_d = S_OUT;
      end
      S_BRD: begin
        cmd_o.boost_pop = 1'b1;
        state_d         = S_BMV;
      end
      S_BMV: begin
        cmd_o.boost_mv = 1'b1;
        state_d        = S_CHK;
      end
      S_OUT: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

### src/mlfq_dp.sv
// datapath: level queues, level store, quantum compare, boost walk
module mlfq_dp #(
  parameter int unsigned NumLevels = 4,
  parameter int unsigned MaxPids   = 64,
  parameter int unsigned Capacity  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mlfq_pkg::cmd_t                    cmd_i,
  input  logic [mlfq_pkg::ReqWidth-1:0]     req_i,
  input  logic [mlfq_pkg::PidWidth-1:0]     pid_i,
  input  logic [mlfq_pkg::QuantWidth-1:0]   run_i,
  input  logic [4*mlfq_pkg::QuantWidth-1:0] quant_i,
  input  logic [mlfq_pkg::QuantWidth-1:0]   interval_i,
  output mlfq_pkg::sts_t                    sts_o,
  output logic [mlfq_pkg::PidWidth+3:0]     res_o
);
  import mlfq_pkg::*;

  localparam int unsigned LvlW  = (NumLevels > 1) ? $clog2(NumLevels) : 1;
  localparam int unsigned PosW  = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned SumW  = PosW + 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned PidIW = (MaxPids > 1) ? $clog2(MaxPids) : 1;
  localparam int unsigned AddrW = LvlW + PosW;
  localparam logic [LvlW-1:0] LastLvl = LvlW'(NumLevels - 1);

  logic [PidWidth-1:0] slots [1 << AddrW];
  logic [1:0]          lvl_mem [MaxPids];
  logic [MaxPids-1:0]  lvl_vld_q;

  logic [PosW-1:0] head_q  [NumLevels];
  logic [CntW-1:0] count_q [NumLevels];
  logic [CntW-1:0] total_q;
  logic [QuantWidth-1:0] ticks_q;

  logic [ReqWidth-1:0] req_q;
  logic [PidWidth-1:0] pid_q;
  logic [QuantWidth-1:0] run_q;
  logic [1:0] lvl_rd_q;
  logic lvl_known;
  logic boost_q;
  logic [PidWidth-1:0] rd_pid_q;
  logic pvalid_q, preempt_q, drop_q;
  logic [PidWidth-1:0] ppid_q;

  // level of the request id, zero when beyond the store or never written
  logic in_range;
  logic [LvlW-1:0] cur_lvl, dem_lvl, pick_lvl, wr_lvl;
  logic [LvlW-1:0] blvl_d_search;
  logic pick_any, upper_busy;
  logic [SumW-1:0] tail_sum;
  logic [PosW-1:0] tail_pos;
  logic do_push, do_pop, full;
  logic [LvlW-1:0] pop_lvl;
  logic [PidWidth-1:0] push_pid;
  logic set_lvl;
  logic [1:0] set_val;
  logic [PidWidth-1:0] set_pid;
  logic [QuantWidth-1:0] ticks_inc;
  logic [1:0] q_sel;

  assign in_range = (32'(pid_q) < MaxPids);
  assign cur_lvl  = (in_range && lvl_known) ? LvlW'(lvl_rd_q) : '0;
  assign dem_lvl  = (cur_lvl == LastLvl) ? cur_lvl : cur_lvl + 1'b1;
  assign full     = (32'(total_q) >= Capacity);
  assign q_sel    = 2'(cur_lvl);

  always_comb begin
    pick_any   = 1'b0;
    pick_lvl   = '0;
    upper_busy = 1'b0;
    for (int l = NumLevels - 1; l >= 0; l--) begin
      if (count_q[l] != '0) begin
        pick_any = 1'b1;
        pick_lvl = LvlW'(l);
      end
    end
    blvl_d_search = '0;
    for (int l = NumLevels - 1; l >= 1; l--) begin
      if (count_q[l] != '0) begin
        upper_busy    = 1'b1;
        blvl_d_search = LvlW'(l);
      end
    end
  end

  assign ticks_inc = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    pop_lvl  = pick_lvl;
    wr_lvl   = '0;
    push_pid = pid_q;
    set_lvl  = 1'b0;
    set_val  = 2'(dem_lvl);
    set_pid  = pid_q;
    if (cmd_i.exec) begin
      case (req_q)
        REQ_ADD: begin
          do_push = !full;
          wr_lvl  = cur_lvl;
        end
        REQ_PICK: do_pop = pick_any;
        REQ_REQUEUE: begin
          do_push = !full;
          wr_lvl  = dem_lvl;
          set_lvl = in_range;
        end
        default: ;
      endcase
    end
    if (cmd_i.boost_pop) begin
      do_pop  = 1'b1;
      pop_lvl = blvl_d_search;
    end
    if (cmd_i.boost_mv) begin
      // pop and push cancel in the total, so capacity cannot overflow
      do_push  = 1'b1;
      wr_lvl   = '0;
      push_pid = rd_pid_q;
      set_pid  = rd_pid_q;
      set_val  = 2'd0;
      set_lvl  = (32'(rd_pid_q) < MaxPids);
    end
  end

  // head plus count stays below twice the capacity, one subtract wraps it
  assign tail_sum = SumW'(head_q[wr_lvl]) + SumW'(count_q[wr_lvl]);
  assign tail_pos = (tail_sum >= SumW'(Capacity)) ? PosW'(tail_sum - SumW'(Capacity))
                                                  : PosW'(tail_sum);

  // queue slot memory and level store
  always_ff @(posedge clk_i) begin
    if (do_push) slots[{wr_lvl, tail_pos}] <= push_pid;
    if (do_pop)  rd_pid_q <= slots[{pop_lvl, head_q[pop_lvl]}];
    if (set_lvl) lvl_mem[PidIW'(set_pid)] <= set_val;
    if (cmd_i.load) lvl_rd_q <= lvl_mem[PidIW'(pid_i)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_vld_q <= '0;
      total_q   <= '0;
      ticks_q   <= '0;
      boost_q   <= 1'b0;
      lvl_known <= 1'b0;
      for (int l = 0; l < NumLevels; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
    end else begin
      if (cmd_i.load) lvl_known <= lvl_vld_q[PidIW'(pid_i)] && (32'(pid_i) < MaxPids);
      if (set_lvl) lvl_vld_q[PidIW'(set_pid)] <= 1'b1;
      if (do_pop) begin
        head_q[pop_lvl]  <= (32'(head_q[pop_lvl]) == Capacity - 1) ? '0
                                                                   : head_q[pop_lvl] + 1'b1;
        count_q[pop_lvl] <= count_q[pop_lvl] - 1'b1;
      end
      if (do_push) count_q[wr_lvl] <= count_q[wr_lvl] + 1'b1;
      // a push and a pop never share a cycle
      if (do_push) total_q <= total_q + 1'b1;
      else if (do_pop) total_q <= total_q - 1'b1;
      if (cmd_i.load) boost_q <= 1'b0;
      if (cmd_i.exec && req_q == REQ_TICK) begin
        if (interval_i != '0 && ticks_inc >= interval_i) begin
          ticks_q <= '0;
          boost_q <= 1'b1;
        end else begin
          ticks_q <= ticks_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      pid_q <= pid_i;
      run_q <= run_i;
    end
    if (cmd_i.exec) begin
      pvalid_q  <= (req_q == REQ_PICK) && pick_any;
      preempt_q <= (req_q == REQ_QUERY) &&
                   (run_q >= quant_i[QuantWidth*q_sel +: QuantWidth]);
      drop_q    <= ((req_q == REQ_ADD) || (req_q == REQ_REQUEUE)) && full;
    end
    if (cmd_i.exec && req_q == REQ_PICK && pick_any) ppid_q <= slots[{pick_lvl, head_q[pick_lvl]}];
    else if (cmd_i.exec) ppid_q <= '0;
  end

  assign sts_o.boost_start = boost_q;
  assign sts_o.upper_busy  = upper_busy;
  assign res_o = {drop_q, (total_q == '0), preempt_q, ppid_q, pvalid_q};
endmodule

### src/mlfq_scheduler_top.sv
// top level of the multilevel feedback queue scheduler
// usage:
//   requests arrive on the s_axis group: tdata holds req_type, process_id and
//   run_time; one result per request leaves on m_axis: tdata holds
//   picked_valid, picked_pid, preempt_now, all_empty and dropped
//   configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle: quantum per level (0..3) and boost interval (4)
//   result path: m_axis_tvalid rises after the exec, check and output states
//   when the output register is free; a tick that fires a boost adds a pop and
//   a move state for each id queued below level 0, set by the single-port slot
//   memory walk; the block takes one request at a time
//   reset clears queue counts, heads, level-valid bits and the tick counter;
//   slot memory holds no reset value and needs no clearing pass
//   when the receiver stalls the result waits in the output register and the
//   block waits with it before taking the next request
module mlfq_scheduler_top #(
  parameter int unsigned NUM_LEVELS = 4,
  parameter int unsigned MAX_PIDS   = 64,
  parameter int unsigned CAPACITY   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // req_type[2:0], process_id[8:3], run_time[24:9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // picked_valid, picked_pid[6:1], preempt_now, all_empty, dropped
  input  logic        cfg_we_i,
  input  logic [mlfq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mlfq_pkg::QuantWidth-1:0] cfg_data_i
);
  import mlfq_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [PidWidth+3:0] res;
  logic in_fire;
  logic [QuantWidth-1:0] quant_q [4];
  logic [QuantWidth-1:0] interval_q;
  logic [4*QuantWidth-1:0] quant_flat;
  logic vld_q;
  logic [PidWidth+3:0] data_q;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign quant_flat = {quant_q[3], quant_q[2], quant_q[1], quant_q[0]};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q[0] <= 16'd1;
      quant_q[1] <= 16'd2;
      quant_q[2] <= 16'd4;
      quant_q[3] <= 16'd8;
      interval_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_Q0:    quant_q[0] <= cfg_data_i;
        CFG_Q1:    quant_q[1] <= cfg_data_i;
        CFG_Q2:    quant_q[2] <= cfg_data_i;
        CFG_Q3:    quant_q[3] <= cfg_data_i;
        CFG_BOOST: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mlfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (!vld_q || m_axis_tready),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  mlfq_dp #(
    .NumLevels (NUM_LEVELS),
    .MaxPids   (MAX_PIDS),
    .Capacity  (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (s_axis_tdata[2:0]),
    .pid_i      (s_axis_tdata[8:3]),
    .run_i      (s_axis_tdata[24:9]),
    .quant_i    (quant_flat),
    .interval_i (interval_q),
    .sts_o      (sts),
    .res_o      (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (cmd.out_load) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) data_q <= res;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {6'd0, data_q};
endmodule

### sim/tb_mlfq_scheduler_top.sv
// testbench for the multilevel feedback queue scheduler: stream requests, predicted results
`timescale 1ns / 1ps

module tb_mlfq_scheduler_top;
  import mlfq_pkg::*;

  localparam int NumLv = 4;
  localparam int NumPid = 64;
  localparam int Cap = 64;
  localparam int WatchLimit = 20000;

  // lowest field in the lowest bits
  typedef struct packed {
    logic [15:0] run;
    logic [5:0]  pid;
    logic [2:0]  req;
  } sched_req_t;

  typedef struct packed {
    logic       dropped;
    logic       all_empty;
    logic       preempt_now;
    logic [5:0] picked_pid;
    logic       picked_valid;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [QuantWidth-1:0] cfg_data_i = '0;

  mlfq_scheduler_top dut (.*);

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the scheduler state
  logic [15:0] quantum_q[NumLv];
  logic [15:0] boost_ivl;
  logic [5:0]  slot_mem[NumLv][Cap];
  int          head_q[NumLv];
  int          count_q[NumLv];
  logic [1:0]  level_of_pid[NumPid];
  int          queued_total;
  int          tick_count;

  sched_req_t  pending_reqs[$];
  sched_res_t  expected_res[$];
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          feeding_done = 1'b0;

  function automatic bit push_pid(int lvl, logic [5:0] pid);
    if (queued_total >= Cap) return 1'b0;
    slot_mem[lvl][(head_q[lvl] + count_q[lvl]) % Cap] = pid;
    count_q[lvl]++;
    queued_total++;
    return 1'b1;
  endfunction

  function automatic logic [5:0] pop_pid(int lvl);
    logic [5:0] pid;
    pid = slot_mem[lvl][head_q[lvl]];
    head_q[lvl] = (head_q[lvl] + 1) % Cap;
    count_q[lvl]--;
    queued_total--;
    return pid;
  endfunction

  // work out the result of one accepted request
  function automatic sched_res_t schedule_step(sched_req_t r);
    sched_res_t res;
    int lvl;
    logic [5:0] p;
    res = '0;
    case (r.req)
      REQ_ADD: res.dropped = !push_pid(level_of_pid[r.pid], r.pid);
      REQ_PICK: begin
        for (int l = 0; l < NumLv; l++) begin
          if (count_q[l] != 0 && !res.picked_valid) begin
            res.picked_pid = pop_pid(l);
            res.picked_valid = 1'b1;
          end
        end
      end
      REQ_QUERY: res.preempt_now = r.run >= quantum_q[level_of_pid[r.pid]];
      REQ_REQUEUE: begin
        lvl = level_of_pid[r.pid];
        if (lvl + 1 < NumLv) lvl++;
        level_of_pid[r.pid] = lvl[1:0];
        res.dropped = !push_pid(lvl, r.pid);
      end
      REQ_TICK: begin
        if (tick_count != 16'hffff) tick_count++;
        if (boost_ivl > 0 && tick_count >= boost_ivl) begin
          for (int l = 1; l < NumLv; l++) begin
            while (count_q[l] != 0) begin
              p = pop_pid(l);
              level_of_pid[p] = 2'd0;
              void'(push_pid(0, p));
            end
          end
          tick_count = 0;
        end
      end
      default: ;
    endcase
    res.all_empty = queued_total == 0;
    return res;
  endfunction

  // driver: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_res.push_back(schedule_step(sched_req_t'(s_axis_tdata[24:0])));
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        s_axis_tdata <= {7'd0, pending_reqs.pop_front()};
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: phases of full speed, random and heavy stalling
  int stall_phase = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_phase <= $urandom_range(0, 2);
    case (stall_phase)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= $urandom_range(0, 7) == 0;
    endcase
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    sched_res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = sched_res_t'(m_axis_tdata[9:0]);
      if (expected_res.size() == 0) begin
        $error("result with nothing expected: %h", got);
        err_count++;
      end else begin
        want = expected_res.pop_front();
        if (got.picked_valid !== want.picked_valid) begin
          $error("picked_valid exp %0d got %0d", want.picked_valid, got.picked_valid);
          err_count++;
        end
        if (got.picked_pid !== want.picked_pid) begin
          $error("picked_pid exp %0d got %0d", want.picked_pid, got.picked_pid);
          err_count++;
        end
        if (got.preempt_now !== want.preempt_now) begin
          $error("preempt_now exp %0d got %0d", want.preempt_now, got.preempt_now);
          err_count++;
        end
        if (got.all_empty !== want.all_empty) begin
          $error("all_empty exp %0d got %0d", want.all_empty, got.all_empty);
          err_count++;
        end
        if (got.dropped !== want.dropped) begin
          $error("dropped exp %0d got %0d", want.dropped, got.dropped);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles where no request is accepted at either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_reqs.size() == 0 && expected_res.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb_mlfq_scheduler_top: done, errors");
        $finish;
      end
    end
  end

  function automatic sched_req_t mk(req_e r, int pid, int run);
    sched_req_t q;
    q.req = r;
    q.pid = pid[5:0];
    q.run = run[15:0];
    return q;
  endfunction

  // random request, weighted towards well-formed scheduling traffic
  function automatic sched_req_t rand_req();
    int k;
    logic [2:0] r;
    k = $urandom_range(0, 99);
    if (k < 30) r = REQ_ADD;
    else if (k < 52) r = REQ_PICK;
    else if (k < 67) r = REQ_QUERY;
    else if (k < 84) r = REQ_REQUEUE;
    else if (k < 97) r = REQ_TICK;
    else r = 3'($urandom_range(5, 7));
    return {16'(($urandom_range(0, 1)) ? $urandom_range(0, 20) : $urandom),
            6'($urandom_range(0, 63)), r};
  endfunction

  // wait until every prediction has been met, plus boost walk slack
  task automatic drain();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_res.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BOOST) boost_ivl = val;
    else quantum_q[idx] = val;
    @(posedge clk_i);
  endtask

  initial begin
    quantum_q = '{16'd1, 16'd2, 16'd4, 16'd8};
    boost_ivl = '0;
    head_q = '{default: 0};
    count_q = '{default: 0};
    level_of_pid = '{default: 2'd0};
    queued_total = 0;
    tick_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset quanta, unknown ids, empty pick, demotion to the floor
    pending_reqs.push_back(mk(REQ_PICK, 0, 0));
    pending_reqs.push_back(mk(REQ_QUERY, 63, 0));
    pending_reqs.push_back(mk(REQ_QUERY, 63, 1));
    pending_reqs.push_back(mk(REQ_ADD, 0, 65535));
    pending_reqs.push_back(mk(REQ_ADD, 63, 0));
    pending_reqs.push_back(mk(REQ_ADD, 63, 0));
    for (int i = 0; i < 5; i++) pending_reqs.push_back(mk(REQ_REQUEUE, 42, 0));
    pending_reqs.push_back(mk(REQ_QUERY, 42, 7));
    pending_reqs.push_back(mk(REQ_QUERY, 42, 8));
    pending_reqs.push_back(mk(REQ_TICK, 0, 0));
    pending_reqs.push_back(sched_req_t'({16'haaaa, 6'd21, 3'd5}));
    pending_reqs.push_back(sched_req_t'({16'h5555, 6'd42, 3'd7}));
    for (int i = 0; i < 9; i++) pending_reqs.push_back(mk(REQ_PICK, 0, 0));
    drain();

    // extremes of the quanta, boost every tick
    write_cfg(CFG_Q0, 16'd0);
    write_cfg(CFG_Q1, 16'hffff);
    write_cfg(CFG_Q2, 16'd0);
    write_cfg(CFG_Q3, 16'hffff);
    write_cfg(CFG_BOOST, 16'd1);
    // fill to capacity with demoted ids, overflow, then boost
    for (int i = 0; i < 66; i++) pending_reqs.push_back(mk(REQ_REQUEUE, i % 64, 0));
    pending_reqs.push_back(mk(REQ_ADD, 5, 0));
    pending_reqs.push_back(mk(REQ_QUERY, 3, 65535));
    pending_reqs.push_back(mk(REQ_QUERY, 3, 65534));
    pending_reqs.push_back(mk(REQ_TICK, 0, 0));
    pending_reqs.push_back(mk(REQ_QUERY, 3, 0));
    drain();

    // random phases under different settings
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_Q0, ph == 5 ? 16'hffff : 16'($urandom_range(0, 20)));
      write_cfg(CFG_Q1, 16'($urandom_range(0, 20)));
      write_cfg(CFG_Q2, 16'($urandom_range(0, 20)));
      write_cfg(CFG_Q3, ph == 5 ? 16'd0 : 16'($urandom_range(0, 20)));
      case (ph)
        0: write_cfg(CFG_BOOST, 16'd0);
        1: write_cfg(CFG_BOOST, 16'hffff);
        default: write_cfg(CFG_BOOST, 16'($urandom_range(1, 12)));
      endcase
      for (int i = 0; i < 200; i++) pending_reqs.push_back(rand_req());
      drain();
    end

    if (err_count == 0) begin
      $display("tb_mlfq_scheduler_top: done, clean");
    end else begin
      $display("tb_mlfq_scheduler_top: done, errors");
    end
    $finish;
  end

endmodule

### mlfq_scheduler_top.f
src/mlfq_pkg.sv
src/mlfq_ctrl.sv
src/mlfq_dp.sv
src/mlfq_scheduler_top.sv
sim/tb_mlfq_scheduler_top.sv
